@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker modules
// All macros sample on clk and stay quiet while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property.
`define THST_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define THST_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define THST_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/thst_pkg.sv @@
// ---------------------------------------------------------------------------
// thst_pkg
// Types, codes and constants of the thermal head strobe timer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package thst_pkg;

	localparam int DEF_NUM_GROUPS      = 6;
	localparam int DEF_BYTES_PER_GROUP = 8;
	localparam int DEF_COUNTER_BITS    = 24;

	localparam int GROUP_W     = 3;   // groups 0..7 at most
	localparam int SUM_W       = 11;
	localparam int SUM_EXT_W   = SUM_W + 1;
	localparam int EXTRA_W     = 10;
	localparam int EXTRA_ALL_W = EXTRA_W << GROUP_W;
	localparam int MASK_W      = 6;
	localparam int CFG_DATA_W  = 60;
	localparam int CFG_IDX_W   = 3;
	localparam int CMD_DEPTH   = 2;
	localparam int RES_DEPTH   = 2;

	localparam logic [SUM_W-1:0]   SUM_MAX     = 11'd2047;
	localparam logic [GROUP_W-1:0] ALL_SELECT  = 3'd6;
	localparam logic [7:0]         HEAT_RESET  = 8'd64;
	localparam logic [6:0]         PERCENT_DIV = 7'd100;
	// floor(2^32 / 100); quotient estimate is low by at most one
	localparam logic [25:0]        RECIP_100   = 26'd42949672;

	localparam logic [CFG_IDX_W-1:0] CFG_HEAT_DENSITY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_PULSE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOAD_COEF    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GROUP_EXTRA  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS    = 3'd4;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_FIRE = 2'd1,
		OP_TICK = 2'd2,
		OP_STOP = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PULSE = 2'd1,
		PH_GAP   = 2'd2
	} phase_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_EXEC,
		BK_SQ,
		BK_COEF,
		BK_SUM,
		BK_DENS,
		BK_RECIP,
		BK_REM,
		BK_START,
		BK_SETTLE,
		BK_EMIT
	} back_state_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] data_byte;
		logic [5:0] byte_index;
		logic [2:0] group_select;
	} in_item_t;

	typedef struct packed {
		logic [5:0] strobe_mask;
		logic       busy_res;
		logic [2:0] active_group;
		logic       sequence_done;
		logic       fire_ignored;
	} out_item_t;

	typedef struct packed {
		op_t                kind;
		logic [7:0]         data_byte;
		logic               clear_sums;
		logic               grp_valid;
		logic [GROUP_W-1:0] grp_idx;
		logic               sel_valid;
		logic               sel_all;
		logic [GROUP_W-1:0] sel_group;
	} cmd_t;

endpackage

@@ rtl/thst_fifo.sv @@
// ---------------------------------------------------------------------------
// thst_fifo
// Small synchronous queue; push when full and pop when empty are dropped.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module thst_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = cnt_q == CW'(DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ rtl/thst_front.sv @@
// ---------------------------------------------------------------------------
// thst_front
// Accepts items, decodes them into commands and queues them for the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module thst_front import thst_pkg::*; #(
	parameter int NUM_GROUPS      = DEF_NUM_GROUPS,
	parameter int BYTES_PER_GROUP = DEF_BYTES_PER_GROUP
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_item_t item,
	output logic     cmd_valid,
	output cmd_t     cmd,
	input  logic     cmd_pop
);

	logic [GROUP_W:0] grp_full;
	logic             cmd_empty;
	cmd_t             cmd_d;

	// byte position to group by compares against the group boundaries;
	// bytes past the last group land on NUM_GROUPS
	always_comb begin
		grp_full = '0;
		for (int g = 1; g <= NUM_GROUPS; g++) begin
			if (int'(item.byte_index) >= g * BYTES_PER_GROUP) begin
				grp_full = (GROUP_W + 1)'(g);
			end
		end
	end

	always_comb begin
		cmd_d            = '0;
		cmd_d.kind       = op_t'(item.operation);
		cmd_d.data_byte  = item.data_byte;
		cmd_d.clear_sums = item.byte_index == '0;
		cmd_d.grp_valid  = grp_full < (GROUP_W + 1)'(NUM_GROUPS);
		cmd_d.grp_idx    = grp_full[GROUP_W-1:0];
		cmd_d.sel_all    = item.group_select == ALL_SELECT;
		cmd_d.sel_valid  = cmd_d.sel_all
			|| ({1'b0, item.group_select} < (GROUP_W + 1)'(NUM_GROUPS));
		cmd_d.sel_group  = cmd_d.sel_all ? '0 : item.group_select;
	end

	thst_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd_d),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd),
		.empty  (cmd_empty)
	);

	assign cmd_valid = !cmd_empty;

endmodule

@@ rtl/thst_back.sv @@
// ---------------------------------------------------------------------------
// thst_back
// Strobe sequencer: group sums, pulse width arithmetic, phase timing, results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module thst_back import thst_pkg::*; #(
	parameter int NUM_GROUPS   = DEF_NUM_GROUPS,
	parameter int COUNTER_BITS = DEF_COUNTER_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  cmd_valid,
	input  cmd_t                  cmd,
	output logic                  cmd_pop,
	output logic                  empty,
	input  logic                  pop,
	output out_item_t             result
);

	localparam int GIDX_W = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
	localparam logic [32:0] CNT_MAX = (33'd1 << COUNTER_BITS) - 33'd1;

	back_state_t state_q, state_d;

	// configuration
	logic [7:0]            density_q;
	logic [15:0]           base_q;
	logic [15:0]           coef_q;
	logic [CFG_DATA_W-1:0] extra_q;
	logic [15:0]           gap_q;

	// sequence state
	logic [SUM_W-1:0]        sums_q [NUM_GROUPS];
	phase_t                  phase_q;
	logic [COUNTER_BITS-1:0] cnt_q;
	logic [GROUP_W-1:0]      grp_q;
	logic                    all_q;
	logic                    done_q;
	logic                    ignored_q;
	cmd_t                    cmd_q;

	// width arithmetic
	logic [21:0] sq_q;
	logic [37:0] prod_q;
	logic [22:0] raw_q;
	logic [30:0] scaled_q;
	logic [24:0] quot_q;
	logic [7:0]  rem_q;

	logic [SUM_W-1:0]       cur_sum;
	logic [EXTRA_ALL_W-1:0] extra_wide;
	logic [EXTRA_W-1:0]     extra_cur;
	logic [SUM_W-1:0]       load_base;
	logic [SUM_EXT_W-1:0]   load_sum;
	logic [GROUP_W:0]       grp_next;
	logic                   more_groups;
	logic                   phase_end;
	logic [56:0]            recip_prod;
	logic [30:0]            rem_full;
	logic [25:0]            width_q26;
	logic [32:0]            width33;
	logic                   res_full;
	logic                   res_push;
	out_item_t              res_d;

	assign cur_sum     = sums_q[grp_q[GIDX_W-1:0]];
	assign extra_wide  = EXTRA_ALL_W'(extra_q);
	assign extra_cur   = extra_wide[grp_q * EXTRA_W +: EXTRA_W];
	assign load_base   = cmd_q.clear_sums ? '0 : sums_q[cmd_q.grp_idx[GIDX_W-1:0]];
	assign load_sum    = {1'b0, load_base} + SUM_EXT_W'(cmd_q.data_byte);
	assign grp_next    = {1'b0, grp_q} + 1'b1;
	assign more_groups = all_q && (grp_next < (GROUP_W + 1)'(NUM_GROUPS));
	assign phase_end   = (phase_q != PH_IDLE) && (cnt_q == '0);
	assign recip_prod  = 57'(scaled_q) * 57'(RECIP_100);
	assign rem_full    = scaled_q - 31'(quot_q) * 31'(PERCENT_DIV);
	assign width_q26   = {1'b0, quot_q} + 26'(rem_q >= 8'(PERCENT_DIV));
	assign width33     = 33'(width_q26);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid && !res_full) begin
					state_d = BK_EXEC;
				end
			end
			BK_EXEC: begin
				case (cmd_q.kind)
					OP_FIRE: begin
						if (phase_q != PH_IDLE || !cmd_q.sel_valid) begin
							state_d = BK_EMIT;
						end else begin
							state_d = BK_SQ;
						end
					end
					OP_TICK: state_d = (phase_q == PH_IDLE) ? BK_EMIT : BK_SETTLE;
					default: state_d = BK_EMIT;
				endcase
			end
			BK_SQ:    state_d = BK_COEF;
			BK_COEF:  state_d = BK_SUM;
			BK_SUM:   state_d = BK_DENS;
			BK_DENS:  state_d = BK_RECIP;
			BK_RECIP: state_d = BK_REM;
			BK_REM:   state_d = BK_START;
			BK_START: state_d = BK_SETTLE;
			BK_SETTLE: begin
				if (!phase_end) begin
					state_d = BK_EMIT;
				end else if (phase_q == PH_PULSE) begin
					state_d = BK_SETTLE;
				end else if (more_groups) begin
					state_d = BK_SQ;
				end else begin
					state_d = BK_EMIT;
				end
			end
			BK_EMIT: state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		cmd_pop  = (state_q == BK_IDLE) && cmd_valid && !res_full;
		res_push = state_q == BK_EMIT;
	end

	always_comb begin
		res_d               = '0;
		res_d.strobe_mask   = (phase_q == PH_PULSE) ? MASK_W'(8'd1 << grp_q) : '0;
		res_d.busy_res      = phase_q != PH_IDLE;
		res_d.active_group  = (phase_q != PH_IDLE) ? grp_q : '0;
		res_d.sequence_done = done_q;
		res_d.fire_ignored  = ignored_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			density_q <= HEAT_RESET;
			base_q    <= '0;
			coef_q    <= '0;
			extra_q   <= '0;
			gap_q     <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_HEAT_DENSITY: density_q <= cfg_data[7:0];
				CFG_BASE_PULSE:   base_q    <= cfg_data[15:0];
				CFG_LOAD_COEF:    coef_q    <= cfg_data[15:0];
				CFG_GROUP_EXTRA:  extra_q   <= cfg_data;
				CFG_GAP_TICKS:    gap_q     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// arithmetic registers carry no reset
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		case (state_q)
			BK_SQ:    sq_q     <= 22'(cur_sum) * 22'(cur_sum);
			BK_COEF:  prod_q   <= 38'(sq_q) * 38'(coef_q);
			BK_SUM:   raw_q    <= 23'(base_q) + 23'(prod_q[37:16]) + 23'(extra_cur);
			BK_DENS:  scaled_q <= 31'(raw_q) * 31'(density_q);
			BK_RECIP: quot_q   <= recip_prod[56:32];
			BK_REM:   rem_q    <= rem_full[7:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			phase_q   <= PH_IDLE;
			cnt_q     <= '0;
			grp_q     <= '0;
			all_q     <= 1'b0;
			done_q    <= 1'b0;
			ignored_q <= 1'b0;
			for (int i = 0; i < NUM_GROUPS; i++) begin
				sums_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			case (state_q)
				BK_IDLE: begin
					done_q    <= 1'b0;
					ignored_q <= 1'b0;
				end
				BK_EXEC: begin
					case (cmd_q.kind)
						OP_LOAD: begin
							if (cmd_q.clear_sums) begin
								for (int i = 0; i < NUM_GROUPS; i++) begin
									sums_q[i] <= '0;
								end
							end
							if (cmd_q.grp_valid) begin
								sums_q[cmd_q.grp_idx[GIDX_W-1:0]] <= load_sum[SUM_W]
									? SUM_MAX : load_sum[SUM_W-1:0];
							end
						end
						OP_FIRE: begin
							if (phase_q != PH_IDLE) begin
								ignored_q <= 1'b1;
							end else if (cmd_q.sel_valid) begin
								all_q <= cmd_q.sel_all;
								grp_q <= cmd_q.sel_group;
							end
						end
						OP_TICK: begin
							if (phase_q != PH_IDLE && cnt_q != '0) begin
								cnt_q <= cnt_q - 1'b1;
							end
						end
						default: begin
							phase_q <= PH_IDLE;
							cnt_q   <= '0;
							grp_q   <= '0;
							all_q   <= 1'b0;
						end
					endcase
				end
				BK_START: begin
					if (width33 == '0) begin
						phase_q <= PH_GAP;
						cnt_q   <= COUNTER_BITS'(gap_q);
					end else begin
						phase_q <= PH_PULSE;
						cnt_q   <= COUNTER_BITS'((width33 > CNT_MAX) ? CNT_MAX : width33);
					end
				end
				BK_SETTLE: begin
					if (phase_end) begin
						if (phase_q == PH_PULSE) begin
							phase_q <= PH_GAP;
							cnt_q   <= COUNTER_BITS'(gap_q);
						end else if (more_groups) begin
							grp_q <= grp_next[GROUP_W-1:0];
						end else begin
							phase_q <= PH_IDLE;
							cnt_q   <= '0;
							grp_q   <= '0;
							all_q   <= 1'b0;
							done_q  <= 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	thst_fifo #(
		.WIDTH ($bits(out_item_t)),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_d),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

@@ rtl/thermal_head_strobe_timer_core.sv @@
// ---------------------------------------------------------------------------
// thermal_head_strobe_timer_core
// Load, stop and idle tick items pass the execute and emit states of the sequencer, a
// running tick the settle state as well; each pulse that ends adds a settle pass and
// each group started the multiply chain and /100 states. The sequencer handles one item
// at a time; the 2-entry command queue lets the input keep accepting while it works.
// arst_n clears queues, sums, sequence state and loads register reset values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module thermal_head_strobe_timer_core import thst_pkg::*; #(
	parameter int NUM_GROUPS      = DEF_NUM_GROUPS,
	parameter int BYTES_PER_GROUP = DEF_BYTES_PER_GROUP,
	parameter int COUNTER_BITS    = DEF_COUNTER_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  in_item_t              item,
	output logic                  empty,
	input  logic                  pop,
	output out_item_t             result,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	thst_front #(
		.NUM_GROUPS      (NUM_GROUPS),
		.BYTES_PER_GROUP (BYTES_PER_GROUP)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	thst_back #(
		.NUM_GROUPS   (NUM_GROUPS),
		.COUNTER_BITS (COUNTER_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

@@ rtl/thst_checker.sv @@
// ---------------------------------------------------------------------------
// thst_checker
// Port-level checks on the result stream of the strobe timer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module thst_checker import thst_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      empty,
	input logic      pop,
	input out_item_t result
);

	`THST_ASSERT_IMPL(a_strobe_busy, !empty && (result.strobe_mask != '0), result.busy_res && $onehot(result.strobe_mask), "strobe high outside a running sequence")
	`THST_ASSERT_IMPL(a_idle_clean, !empty && !result.busy_res, (result.active_group == '0) && (result.strobe_mask == '0), "idle result shows a group or strobe")
	`THST_ASSERT_IMPL(a_done_idle, !empty && result.sequence_done, !result.busy_res && !result.fire_ignored, "sequence done while still busy")
	`THST_ASSERT_IMPL(a_ignored_busy, !empty && result.fire_ignored, result.busy_res, "fire flagged ignored while idle")
	`THST_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(result), "waiting result changed")

endmodule

bind thermal_head_strobe_timer_core thst_checker u_thst_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
